// File: rtl/gltr_pkg.sv
// Shared constants and types for the grid line collision trace unit.
`default_nettype none

package gltr_pkg;

  // Map storage limits
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  // Field widths
  localparam int FIELD_W   = 8;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  // Signed walk coordinate: covers -1 up to the widest register value
  localparam int CW        = CFG_W + 1;
  // Bresenham error term
  localparam int EW        = FIELD_W + 3;

  // Largest register value that still takes effect
  localparam int WIDTH_CAP  = (MAX_WIDTH < 2**CFG_W) ? MAX_WIDTH : 2**CFG_W - 1;
  localparam int HEIGHT_CAP = (MAX_HEIGHT < 2**CFG_W) ? MAX_HEIGHT : 2**CFG_W - 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;

  // Request functions
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_TRACE = 1'b1;

  typedef logic [FIELD_W-1:0]   field_t;
  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [EW-1:0] err_t;

endpackage

`default_nettype wire

// File: rtl/gltr_in_if.sv
// Request channel carrying load and trace requests.
`default_nettype none

interface gltr_in_if import gltr_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   func;
  field_t cell_x;
  field_t cell_y;
  logic   passable;
  field_t start_x;
  field_t start_y;
  field_t end_x;
  field_t end_y;

  modport source (output valid, func, cell_x, cell_y, passable,
                  start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, func, cell_x, cell_y, passable,
                  start_x, start_y, end_x, end_y, output ready);
endinterface

`default_nettype wire

// File: rtl/gltr_out_if.sv
// Result channel carrying trace results.
`default_nettype none

interface gltr_out_if import gltr_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   hit;
  field_t stop_x;
  field_t stop_y;

  modport source (output valid, hit, stop_x, stop_y, input ready);
  modport sink   (input valid, hit, stop_x, stop_y, output ready);
endinterface

`default_nettype wire

// File: rtl/gltr_cfg_if.sv
// Configuration write channel.
`default_nettype none

interface gltr_cfg_if import gltr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] addr;
  logic [CFG_W-1:0]     data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

// File: rtl/grid_line_collision_trace_unit.sv
// Grid line collision trace unit: cell map in one RAM, Bresenham walk over it.
// Load request: written into the map at the accepting edge, no result.
// Trace request: each major-axis step runs STEP, MOVE, LINE_CHK; a minor-axis step adds
//   SIDE_B and SIDE_CHK (two corner reads and one line read on one RAM read port);
//   the next request is taken once the result sits in the output register.
// Reset: rst_n synchronous, active low; map size returns to 256 x 256, map
//   contents are kept and are undefined until written.
`default_nettype none

module grid_line_collision_trace_unit import gltr_pkg::*; (
  input wire logic  clk,
  input wire logic  rst_n,
  gltr_in_if.sink   in_ch,
  gltr_out_if.source out_ch,
  gltr_cfg_if.sink  cfg_ch
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_STEP     = 7'b0000010,
    S_SIDE_B   = 7'b0000100,
    S_SIDE_CHK = 7'b0001000,
    S_MOVE     = 7'b0010000,
    S_LINE_CHK = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  // Map address of an in-range cell
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [CFG_W-1:0] row,
                                                  input logic [CFG_W-1:0] col);
    cell_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col));
  endfunction

  // Cell lies outside the map in use
  function automatic logic is_out(input coord_t col, input coord_t row,
                                  input logic [CFG_W-1:0] wl,
                                  input logic [CFG_W-1:0] hl);
    is_out = col[CW-1] | row[CW-1] | (col[CW-2:0] >= wl) | (row[CW-2:0] >= hl);
  endfunction

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] map_w_r, map_h_r;
  logic [CFG_W-1:0] w_lim, h_lim;

  field_t x1_r, x1_nxt, y1_r, y1_nxt;
  logic   sx_neg_r, sx_neg_nxt, sy_neg_r, sy_neg_nxt;
  logic   steep_r, steep_nxt;
  field_t dmaj_r, dmaj_nxt, dmin_r, dmin_nxt;
  field_t cnt_r, cnt_nxt;
  err_t   e_r, e_nxt;
  coord_t cx_r, cx_nxt, cy_r, cy_nxt;
  coord_t px_r, px_nxt, py_r, py_nxt;
  logic   blk_a_r, blk_a_nxt;
  logic   oob_r;

  logic   res_hit_r, res_hit_nxt;
  field_t res_x_r, res_x_nxt, res_y_r, res_y_nxt;

  logic   out_valid_r, out_valid_nxt;
  logic   out_hit_r;
  field_t out_x_r, out_y_r;
  logic   out_load;

  // Trace setup terms
  field_t dx, dy, dmaj_in, dmin_in;
  logic   steep_in;

  // Map access
  coord_t             rd_col, rd_row;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic               rd_data;
  logic               wr_en;
  logic               blocked_now;

  coord_t stx, sty;
  logic   in_fire;

  assign in_fire     = in_ch.valid & in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  // Saturate the configured map size
  assign w_lim = (map_w_r > CFG_W'(WIDTH_CAP))  ? CFG_W'(WIDTH_CAP)  : map_w_r;
  assign h_lim = (map_h_r > CFG_W'(HEIGHT_CAP)) ? CFG_W'(HEIGHT_CAP) : map_h_r;

  // Unit steps toward the end cell
  assign stx = sx_neg_r ? '1 : coord_t'(1);
  assign sty = sy_neg_r ? '1 : coord_t'(1);

  // Setup from the incoming trace request
  always_comb begin
    dx       = (in_ch.end_x > in_ch.start_x) ? in_ch.end_x - in_ch.start_x
                                             : in_ch.start_x - in_ch.end_x;
    dy       = (in_ch.end_y > in_ch.start_y) ? in_ch.end_y - in_ch.start_y
                                             : in_ch.start_y - in_ch.end_y;
    steep_in = dy > dx;
    dmaj_in  = steep_in ? dy : dx;
    dmin_in  = steep_in ? dx : dy;
  end

  // Select the cell to read
  always_comb begin
    rd_col = cx_r;
    rd_row = cy_r;
    unique case (state_r)
      S_STEP: begin
        rd_col = cx_r + stx;
      end
      S_SIDE_B: begin
        rd_row = cy_r + sty;
      end
      S_MOVE: begin
        if (steep_r) begin
          rd_row = cy_r + sty;
        end else begin
          rd_col = cx_r + stx;
        end
      end
      default: begin
      end
    endcase
  end

  assign rd_addr     = cell_addr(rd_row[CW-2:0], rd_col[CW-2:0]);
  assign blocked_now = oob_r | ~rd_data;

  // Load requests write straight into the map
  assign wr_en   = in_fire & (in_ch.func == FUNC_LOAD) &
                   (int'(in_ch.cell_x) < MAX_WIDTH) & (int'(in_ch.cell_y) < MAX_HEIGHT);
  assign wr_addr = cell_addr(CFG_W'(in_ch.cell_y), CFG_W'(in_ch.cell_x));

  gltr_ram #(
    .WIDTH (1),
    .DEPTH (CELL_COUNT)
  ) u_map (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_ch.passable),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Walk sequencer
  always_comb begin
    state_nxt   = state_r;
    x1_nxt      = x1_r;
    y1_nxt      = y1_r;
    sx_neg_nxt  = sx_neg_r;
    sy_neg_nxt  = sy_neg_r;
    steep_nxt   = steep_r;
    dmaj_nxt    = dmaj_r;
    dmin_nxt    = dmin_r;
    cnt_nxt     = cnt_r;
    e_nxt       = e_r;
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    px_nxt      = px_r;
    py_nxt      = py_r;
    blk_a_nxt   = blk_a_r;
    res_hit_nxt = res_hit_r;
    res_x_nxt   = res_x_r;
    res_y_nxt   = res_y_r;
    out_load    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_ch.func)
            FUNC_LOAD: begin
            end
            FUNC_TRACE: begin
              x1_nxt      = in_ch.end_x;
              y1_nxt      = in_ch.end_y;
              res_hit_nxt = 1'b0;
              res_x_nxt   = in_ch.end_x;
              res_y_nxt   = in_ch.end_y;
              sx_neg_nxt  = ~(in_ch.end_x > in_ch.start_x);
              sy_neg_nxt  = ~(in_ch.end_y > in_ch.start_y);
              steep_nxt   = steep_in;
              dmaj_nxt    = dmaj_in;
              dmin_nxt    = dmin_in;
              e_nxt       = $signed({2'b00, dmin_in, 1'b0}) - $signed({3'b000, dmaj_in});
              cx_nxt      = coord_t'({2'b00, in_ch.start_x});
              cy_nxt      = coord_t'({2'b00, in_ch.start_y});
              cnt_nxt     = '0;
              if (in_ch.start_x == in_ch.end_x && in_ch.start_y == in_ch.end_y) begin
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_STEP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_STEP: begin
        px_nxt = cx_r;
        py_nxt = cy_r;
        if (!e_r[EW-1]) begin
          state_nxt = S_SIDE_B;
        end else begin
          state_nxt = S_MOVE;
        end
      end
      S_SIDE_B: begin
        blk_a_nxt = blocked_now;
        state_nxt = S_SIDE_CHK;
      end
      S_SIDE_CHK: begin
        if (blk_a_r && blocked_now) begin
          res_hit_nxt = 1'b1;
          res_x_nxt   = px_r[FIELD_W-1:0];
          res_y_nxt   = py_r[FIELD_W-1:0];
          state_nxt   = S_DONE;
        end else begin
          // Take the minor-axis step
          if (steep_r) begin
            cx_nxt = cx_r + stx;
          end else begin
            cy_nxt = cy_r + sty;
          end
          e_nxt     = e_r - $signed({2'b00, dmaj_r, 1'b0});
          state_nxt = S_MOVE;
        end
      end
      S_MOVE: begin
        // Take the major-axis step; the read of the new cell is in flight
        cx_nxt    = rd_col;
        cy_nxt    = rd_row;
        e_nxt     = e_r + $signed({2'b00, dmin_r, 1'b0});
        state_nxt = S_LINE_CHK;
      end
      S_LINE_CHK: begin
        if (blocked_now) begin
          res_hit_nxt = 1'b1;
          res_x_nxt   = px_r[FIELD_W-1:0];
          res_y_nxt   = py_r[FIELD_W-1:0];
          state_nxt   = S_DONE;
        end else if (cnt_r == dmaj_r - field_t'(1)) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt   = cnt_r + field_t'(1);
          state_nxt = S_STEP;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: hold until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      map_w_r     <= CFG_W'(256);
      map_h_r     <= CFG_W'(256);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.addr)
          REG_MAP_WIDTH:  map_w_r <= cfg_ch.data;
          REG_MAP_HEIGHT: map_h_r <= cfg_ch.data;
          default: begin
          end
        endcase
      end
    end
  end

  // Walk datapath
  always_ff @(posedge clk) begin
    x1_r      <= x1_nxt;
    y1_r      <= y1_nxt;
    sx_neg_r  <= sx_neg_nxt;
    sy_neg_r  <= sy_neg_nxt;
    steep_r   <= steep_nxt;
    dmaj_r    <= dmaj_nxt;
    dmin_r    <= dmin_nxt;
    cnt_r     <= cnt_nxt;
    e_r       <= e_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    blk_a_r   <= blk_a_nxt;
    oob_r     <= is_out(rd_col, rd_row, w_lim, h_lim);
    res_hit_r <= res_hit_nxt;
    res_x_r   <= res_x_nxt;
    res_y_r   <= res_y_nxt;
    if (out_load) begin
      out_hit_r <= res_hit_r;
      out_x_r   <= res_x_r;
      out_y_r   <= res_y_r;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.hit    = out_hit_r;
  assign out_ch.stop_x = out_x_r;
  assign out_ch.stop_y = out_y_r;

  // The end cell is kept for the no-hit result
  logic end_kept;
  assign end_kept = (res_x_r == x1_r) && (res_y_r == y1_r);

  // Error term stays below twice the major length at each step
  a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP) |-> (e_r < $signed({2'b00, dmaj_r, 1'b0})))
    else $error("error term out of bound");

  // Step count never reaches the major length while checking a cell
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LINE_CHK) |-> (cnt_r < dmaj_r))
    else $error("walk ran past the end cell");

  // A result appears only after the walk finished
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result without finished walk");

  // A result without a hit names the end cell
  a_no_hit_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !res_hit_r) |-> end_kept)
    else $error("no-hit result lost the end cell");

endmodule

`default_nettype wire

// File: rtl/gltr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gltr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Testbench for the grid line collision trace unit: self-checking, random and directed.
`timescale 1ns / 100ps

module tb_top;
  import gltr_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 10;
  localparam int SETTLE       = 16;
  localparam int LONG_HOLD    = 300;
  localparam int QUIET_LIMIT  = 8000;
  localparam int WIN          = 10;

  // Register indexes that the block does not decode
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic   func;
    field_t cell_x;
    field_t cell_y;
    logic   passable;
    field_t start_x;
    field_t start_y;
    field_t end_x;
    field_t end_y;
  } grid_req_t;

  typedef struct packed {
    logic   hit;
    field_t stop_x;
    field_t stop_y;
  } trace_res_t;

  logic clk = 1'b0;
  logic rst_n;

  gltr_in_if  in_if ();
  gltr_out_if out_if ();
  gltr_cfg_if cfg_if ();

  grid_line_collision_trace_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Map shadow and register shadow
  bit               cell_free   [CELL_COUNT];
  bit               cell_loaded [CELL_COUNT];
  logic [CFG_W-1:0] map_cols = 9'd256;
  logic [CFG_W-1:0] map_rows = 9'd256;

  grid_req_t  req_fifo[$];
  trace_res_t pending_stops[$];
  int         reqs_sent    = 0;
  int         reqs_taken   = 0;
  int         err_count    = 0;
  int         n_loads      = 0;
  int         n_traces     = 0;
  int         n_hits       = 0;
  int         n_reg_writes = 0;
  int         quiet_cycles = 0;
  bit         gaps_on      = 1'b1;
  bit         hold_results = 1'b0;

  function automatic int cell_index(input int col, input int row);
    return row * MAX_WIDTH + col;
  endfunction

  function automatic bit in_map(input int col, input int row);
    int w;
    int h;
    w = (map_cols < MAX_WIDTH) ? int'(map_cols) : MAX_WIDTH;
    h = (map_rows < MAX_HEIGHT) ? int'(map_rows) : MAX_HEIGHT;
    return col >= 0 && row >= 0 && col < w && row < h;
  endfunction

  function automatic bit cell_blocked(input int col, input int row);
    if (!in_map(col, row)) return 1'b1;
    return !cell_free[cell_index(col, row)];
  endfunction

  function automatic bit cell_unloaded(input int col, input int row);
    return in_map(col, row) && !cell_loaded[cell_index(col, row)];
  endfunction

  // Walk the Bresenham line over the shadow map. Returns 1 with the cell in
  // miss_col/miss_row if the block could fetch a cell never loaded.
  function automatic bit walk_line(input grid_req_t r, output trace_res_t res,
                                   output int miss_col, output int miss_row);
    int x0, y0, x1, y1, sx, sy, dx, dy, dmaj, dmin, err, cx, cy, px, py, i, k, n;
    int pc[3];
    int pr[3];
    bit steep;
    x0 = int'(r.start_x);
    y0 = int'(r.start_y);
    x1 = int'(r.end_x);
    y1 = int'(r.end_y);
    res.hit    = 1'b0;
    res.stop_x = r.end_x;
    res.stop_y = r.end_y;
    miss_col   = 0;
    miss_row   = 0;
    if (x0 == x1 && y0 == y1) return 1'b0;
    sx    = (x1 > x0) ? 1 : -1;
    sy    = (y1 > y0) ? 1 : -1;
    dx    = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy    = (y1 > y0) ? y1 - y0 : y0 - y1;
    steep = dy > dx;
    dmaj  = steep ? dy : dx;
    dmin  = steep ? dx : dy;
    err   = 2 * dmin - dmaj;
    cx    = x0;
    cy    = y0;
    for (i = 0; i < dmaj; i++) begin
      px = cx;
      py = cy;
      // list every cell the hardware may fetch on this step
      if (err >= 0) begin
        pc[0] = cx + sx; pr[0] = cy;
        pc[1] = cx;      pr[1] = cy + sy;
        pc[2] = cx + sx; pr[2] = cy + sy;
        n = 3;
      end else if (steep) begin
        pc[0] = cx; pr[0] = cy + sy;
        n = 1;
      end else begin
        pc[0] = cx + sx; pr[0] = cy;
        n = 1;
      end
      for (k = 0; k < n; k++) begin
        if (cell_unloaded(pc[k], pr[k])) begin
          miss_col = pc[k];
          miss_row = pr[k];
          return 1'b1;
        end
      end
      // diagonal corner closed on both sides
      if (err >= 0) begin
        if (cell_blocked(cx + sx, cy) && cell_blocked(cx, cy + sy)) begin
          res.hit    = 1'b1;
          res.stop_x = field_t'(px);
          res.stop_y = field_t'(py);
          return 1'b0;
        end
        if (steep) cx += sx;
        else cy += sy;
        err -= 2 * dmaj;
      end
      if (steep) cy += sy;
      else cx += sx;
      err += 2 * dmin;
      if (cell_blocked(cx, cy)) begin
        res.hit    = 1'b1;
        res.stop_x = field_t'(px);
        res.stop_y = field_t'(py);
        return 1'b0;
      end
    end
    return 1'b0;
  endfunction

  // Queue one request and predict its effect
  task automatic send_req(input grid_req_t r);
    trace_res_t res;
    int mc;
    int mr;
    if (r.func == FUNC_LOAD) begin
      cell_free[cell_index(r.cell_x, r.cell_y)]   = r.passable;
      cell_loaded[cell_index(r.cell_x, r.cell_y)] = 1'b1;
      n_loads++;
    end else begin
      void'(walk_line(r, res, mc, mr));
      pending_stops = {pending_stops, res};
      n_traces++;
    end
    req_fifo = {req_fifo, r};
    reqs_sent++;
    while (req_fifo.size() > 1) @(posedge clk);
  endtask

  task automatic send_load(input int col, input int row, input bit pass);
    grid_req_t r;
    r          = grid_req_t'({$urandom, $urandom});
    r.func     = FUNC_LOAD;
    r.cell_x   = field_t'(col);
    r.cell_y   = field_t'(row);
    r.passable = pass;
    send_req(r);
  endtask

  task automatic run_trace(input int x0, input int y0, input int x1, input int y1);
    grid_req_t  r;
    trace_res_t res;
    int         mc;
    int         mr;
    r         = grid_req_t'({$urandom, $urandom});
    r.func    = FUNC_TRACE;
    r.start_x = field_t'(x0);
    r.start_y = field_t'(y0);
    r.end_x   = field_t'(x1);
    r.end_y   = field_t'(y1);
    // load every cell the walk may fetch, mostly free
    while (walk_line(r, res, mc, mr))
      send_load(mc, mr, $urandom_range(0, 9) != 0);
    send_req(r);
  endtask

  // Wait until every request is taken and every result is back
  task automatic drain_block();
    while (reqs_taken != reqs_sent || pending_stops.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    drain_block();
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.data  <= val[CFG_W-1:0];
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    if (idx == REG_MAP_WIDTH) map_cols = val[CFG_W-1:0];
    else if (idx == REG_MAP_HEIGHT) map_rows = val[CFG_W-1:0];
    n_reg_writes++;
  endtask

  task automatic test_directed_cases();
    // corner pocket at the far end of the map
    send_load(254, 254, 1'b1);
    send_load(255, 255, 1'b1);
    send_load(255, 254, 1'b0);
    send_load(254, 255, 1'b0);
    // free row with a wall at column 3, free column at x = 0
    send_load(0, 0, 1'b1);
    send_load(1, 0, 1'b1);
    send_load(2, 0, 1'b1);
    send_load(3, 0, 1'b0);
    send_load(0, 1, 1'b1);
    send_load(0, 2, 1'b1);
    run_trace(254, 254, 255, 255);
    run_trace(255, 255, 254, 254);
    run_trace(128, 128, 128, 128);
    run_trace(0, 0, 2, 0);
    run_trace(3, 0, 0, 0);
    run_trace(0, 0, 4, 0);
    run_trace(0, 0, 0, 2);
  endtask

  task automatic test_register_extremes();
    // narrow map: column 2 lies off the edge
    write_reg(REG_MAP_WIDTH, 2);
    run_trace(0, 0, 2, 0);
    // empty map: everything blocked
    write_reg(REG_MAP_WIDTH, 0);
    run_trace(0, 0, 1, 0);
    run_trace(5, 5, 5, 5);
    // oversize values saturate to the full map
    write_reg(REG_MAP_WIDTH, 511);
    write_reg(REG_MAP_HEIGHT, 300);
    run_trace(254, 254, 255, 255);
    run_trace(0, 0, 2, 0);
    // undecoded indexes change nothing
    write_reg(REG_SPARE_A, 0);
    write_reg(REG_SPARE_B, 1);
    run_trace(0, 0, 0, 2);
    write_reg(REG_MAP_WIDTH, 256);
    write_reg(REG_MAP_HEIGHT, 1);
    run_trace(0, 0, 0, 2);
    write_reg(REG_MAP_WIDTH, 1);
    write_reg(REG_MAP_HEIGHT, 1);
    run_trace(0, 0, 3, 3);
  endtask

  task automatic test_local_walks();
    int ox, oy, w, k;
    write_reg(REG_MAP_WIDTH, MAX_WIDTH);
    write_reg(REG_MAP_HEIGHT, MAX_HEIGHT);
    for (w = 0; w < 2; w++) begin
      ox = $urandom_range(0, MAX_WIDTH - WIN);
      oy = $urandom_range(0, MAX_HEIGHT - WIN);
      for (k = 0; k < 60; k++) begin
        gaps_on = (k < 30) ^ w[0];
        if ($urandom_range(0, 7) == 0)
          send_load($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1));
        else
          run_trace(ox + $urandom_range(0, WIN - 1), oy + $urandom_range(0, WIN - 1),
                    ox + $urandom_range(0, WIN - 1), oy + $urandom_range(0, WIN - 1));
      end
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_small_maps();
    int m, k, cols, rows, x0, y0, x1, y1;
    for (m = 0; m < 8; m++) begin
      cols = (m == 0) ? 1 : $urandom_range(1, 12);
      rows = (m == 1) ? 1 : $urandom_range(1, 12);
      write_reg(REG_MAP_WIDTH, cols);
      write_reg(REG_MAP_HEIGHT, rows);
      for (k = 0; k < 12; k++) begin
        x0 = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, cols - 1);
        y0 = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, rows - 1);
        x1 = $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, cols - 1);
        y1 = $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, rows - 1);
        run_trace(x0, y0, x1, y1);
      end
    end
  endtask

  task automatic test_result_backpressure();
    int k;
    write_reg(REG_MAP_WIDTH, MAX_WIDTH);
    write_reg(REG_MAP_HEIGHT, MAX_HEIGHT);
    gaps_on      = 1'b0;
    hold_results = 1'b1;
    for (k = 0; k < 16; k++)
      run_trace($urandom_range(0, 11), $urandom_range(0, 11),
                $urandom_range(0, 11), $urandom_range(0, 11));
    drain_block();
    gaps_on = 1'b1;
  endtask

  // Request driver: one request per handshake, random gaps between while gaps_on is set
  initial begin : req_driver
    grid_req_t cur;
    int        gap;
    in_if.valid    = 1'b0;
    in_if.func     = FUNC_LOAD;
    in_if.cell_x   = '0;
    in_if.cell_y   = '0;
    in_if.passable = 1'b0;
    in_if.start_x  = '0;
    in_if.start_y  = '0;
    in_if.end_x    = '0;
    in_if.end_y    = '0;
    forever begin
      @(negedge clk);
      if (req_fifo.size() == 0) begin
        in_if.valid <= 1'b0;
      end else begin
        cur = req_fifo.pop_front();
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
          in_if.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        in_if.func     <= cur.func;
        in_if.cell_x   <= cur.cell_x;
        in_if.cell_y   <= cur.cell_y;
        in_if.passable <= cur.passable;
        in_if.start_x  <= cur.start_x;
        in_if.start_y  <= cur.start_y;
        in_if.end_x    <= cur.end_x;
        in_if.end_y    <= cur.end_y;
        in_if.valid    <= 1'b1;
        do @(posedge clk); while (!in_if.ready);
        reqs_taken++;
      end
    end
  end

  // Result receiver and checker
  initial begin : result_check
    trace_res_t want;
    int         stall;
    out_if.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(negedge clk);
      if (hold_results) begin
        hold_results = 1'b0;
        stall        = LONG_HOLD;
      end else begin
        stall = gaps_on ? $urandom_range(0, 3) : 0;
      end
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      if (pending_stops.size() == 0) begin
        $display("%0t: unexpected result hit=%0d stop=(%0d,%0d)", $time,
                 out_if.hit, out_if.stop_x, out_if.stop_y);
        err_count++;
      end else begin
        want = pending_stops.pop_front();
        if (out_if.hit !== want.hit) begin
          $display("%0t: hit expected %0d actual %0d", $time, want.hit, out_if.hit);
          err_count++;
        end
        if (out_if.stop_x !== want.stop_x) begin
          $display("%0t: stop_x expected %0d actual %0d", $time, want.stop_x, out_if.stop_x);
          err_count++;
        end
        if (out_if.stop_y !== want.stop_y) begin
          $display("%0t: stop_y expected %0d actual %0d", $time, want.stop_y, out_if.stop_y);
          err_count++;
        end
        if (want.hit) n_hits++;
      end
    end
  end

  // Watchdog: end the run when no channel moves for too long
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : test_sequence
    rst_n        = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.addr  = REG_MAP_WIDTH;
    cfg_if.data  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_register_extremes();
    test_local_walks();
    test_small_maps();
    test_result_backpressure();
    drain_block();
    $display("Ran %0d cell loads and %0d line traces, %0d of them stopped by blocked cells",
             n_loads, n_traces, n_hits);
    $display("Applied %0d register writes: empty, single-row/column, small and saturated maps",
             n_reg_writes);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
